/* design/vtx_pkg.sv */
// Package: payload types, register indexes and shared constants of the vertex transform
`timescale 1ns / 1ps
package vtx_pkg;

  localparam int XY_EXTRA_BITS = 8;
  localparam int DEF_FRACTION_SHIFT = 12;
  localparam int DEF_MAX_VERTICES = 1024;
  localparam int QUOT_BITS = 32;

  typedef enum logic [2:0] {
    REG_ROW_X = 3'd0,
    REG_ROW_Y = 3'd1,
    REG_ROW_Z = 3'd2,
    REG_CENTER_X = 3'd3,
    REG_CENTER_Y = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [9:0] vertex_index;
    logic signed [15:0] x_coord;
    logic signed [15:0] y_coord;
    logic signed [15:0] z_coord;
  } in_beat_t;

  typedef struct packed {
    logic [9:0] vertex_index_out;
    logic signed [15:0] screen_x;
    logic signed [15:0] screen_y;
    logic signed [15:0] depth;
    logic divide_fault;
  } out_beat_t;

  // partial quotient state handed from one divider cell to the next
  typedef struct packed {
    logic valid;
    logic [9:0] idx;
    logic signed [15:0] depth;
    logic signed [15:0] den;
    logic [9:0] cx;
    logic [9:0] cy;
    logic nx_neg;
    logic ny_neg;
    logic [31:0] rx;
    logic [31:0] ry;
    logic [31:0] qx;
    logic [31:0] qy;
  } div_cell_t;

endpackage

/* design/vertex_transform_project.sv */
// Top level: configuration registers, row cells, divider cell chain and output stage
//
//  channel | direction | handshake            | payload
//  in_     | in        | in_valid / in_ready  | in_beat_t
//  out_    | out       | out_valid / out_ready| out_beat_t
//  cfg_    | in        | APB, pready high     | 64-bit registers at 8*i
//
// One vertex a cycle unless stalled. Stages: one multiply stage, one numerator
// stage, 32 divider cells (one quotient bit each) and the output register.
// The whole chain advances together; a full output register with out_ready
// low stalls every stage. Reset clears all valid flags and rows; centres go to 128.
`timescale 1ns / 1ps
module vertex_transform_project
  import vtx_pkg::*;
#(
  parameter int FRACTION_SHIFT = DEF_FRACTION_SHIFT
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_beat_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_beat_t out_data,
  input  logic cfg_psel,
  input  logic cfg_penable,
  input  logic cfg_pwrite,
  input  logic [5:0] cfg_paddr,
  input  logic [63:0] cfg_pwdata,
  output logic [63:0] cfg_prdata,
  output logic cfg_pready
);

  logic [63:0] rowx_r, rowy_r, rowz_r;
  logic [9:0] cx_r, cy_r;
  logic [2:0] widx;
  logic adv;

  assign cfg_pready = 1'b1;
  assign widx = cfg_paddr[5:3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rowx_r <= '0;
      rowy_r <= '0;
      rowz_r <= '0;
      cx_r <= 10'd128;
      cy_r <= 10'd128;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      case (widx)
        REG_ROW_X: rowx_r <= cfg_pwdata;
        REG_ROW_Y: rowy_r <= cfg_pwdata;
        REG_ROW_Z: rowz_r <= cfg_pwdata;
        REG_CENTER_X: cx_r <= cfg_pwdata[9:0];
        REG_CENTER_Y: cy_r <= cfg_pwdata[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (widx)
      REG_ROW_X: cfg_prdata = rowx_r;
      REG_ROW_Y: cfg_prdata = rowy_r;
      REG_ROW_Z: cfg_prdata = rowz_r;
      REG_CENTER_X: cfg_prdata = {54'd0, cx_r};
      REG_CENTER_Y: cfg_prdata = {54'd0, cy_r};
      default: cfg_prdata = '0;
    endcase
  end

  logic out_valid_r;
  out_beat_t out_r;
  assign adv = !out_valid_r || out_ready;
  assign in_ready = adv;

  logic v1_r;
  logic [9:0] idx1_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else if (adv) v1_r <= in_valid;
  end
  always_ff @(posedge clk) begin
    if (adv) idx1_r <= in_data.vertex_index;
  end

  logic signed [31:0] sx, sy, sz;
  logic signed [15:0] cxr, cyr, czr;

  vtx_row_mac #(.FRACTION_SHIFT(FRACTION_SHIFT)) u_rx (
    .clk, .adv, .coeffs(rowx_r), .x(in_data.x_coord), .y(in_data.y_coord),
    .z(in_data.z_coord), .row_sum(sx), .corr(cxr));
  vtx_row_mac #(.FRACTION_SHIFT(FRACTION_SHIFT)) u_ry (
    .clk, .adv, .coeffs(rowy_r), .x(in_data.x_coord), .y(in_data.y_coord),
    .z(in_data.z_coord), .row_sum(sy), .corr(cyr));
  vtx_row_mac #(.FRACTION_SHIFT(FRACTION_SHIFT)) u_rz (
    .clk, .adv, .coeffs(rowz_r), .x(in_data.x_coord), .y(in_data.y_coord),
    .z(in_data.z_coord), .row_sum(sz), .corr(czr));

  logic signed [31:0] nx, ny, offx, offy;
  logic signed [15:0] zt, zp;
  logic [31:0] ax, ay;
  div_cell_t head;

  always_comb begin
    offx = 32'(($signed({{16{rowx_r[63]}}, rowx_r[63:48]}) - 32'(cxr)) <<< XY_EXTRA_BITS);
    offy = 32'(($signed({{16{rowy_r[63]}}, rowy_r[63:48]}) - 32'(cyr)) <<< XY_EXTRA_BITS);
    nx = (sx >>> (FRACTION_SHIFT - XY_EXTRA_BITS)) + offx;
    ny = (sy >>> (FRACTION_SHIFT - XY_EXTRA_BITS)) + offy;
    zt = $signed(rowz_r[63:48]) - czr;
    zp = 16'(sz >>> FRACTION_SHIFT) + zt;
    ax = nx[31] ? 32'(-nx) : nx;
    ay = ny[31] ? 32'(-ny) : ny;
    head.valid = v1_r;
    head.idx = idx1_r;
    head.depth = zp;
    head.den = zp;
    head.cx = cx_r;
    head.cy = cy_r;
    head.nx_neg = nx[31];
    head.ny_neg = ny[31];
    head.rx = ax;
    head.ry = ay;
    head.qx = '0;
    head.qy = '0;
  end

  div_cell_t stage_r;
  always_ff @(posedge clk) begin
    if (!rst_n) stage_r.valid <= 1'b0;
    else if (adv) stage_r <= head;
  end

  div_cell_t chain [0:QUOT_BITS];
  assign chain[0] = stage_r;

  for (genvar i = 0; i < QUOT_BITS; i++) begin : g_div
    vtx_div_cell #(.BIT_POS(QUOT_BITS - 1 - i)) u_cell (
      .clk, .rst_n, .adv, .cell_in(chain[i]), .cell_out(chain[i+1]));
  end

  div_cell_t tl;
  logic qneg_x, qneg_y, fx, fy, zero;
  logic signed [32:0] qx, qy;
  logic signed [15:0] rsx, rsy;

  always_comb begin
    tl = chain[QUOT_BITS];
    zero = (tl.den == 16'sd0);
    qneg_x = tl.nx_neg ^ tl.den[15];
    qneg_y = tl.ny_neg ^ tl.den[15];
    qx = qneg_x ? -$signed({1'b0, tl.qx}) : $signed({1'b0, tl.qx});
    qy = qneg_y ? -$signed({1'b0, tl.qy}) : $signed({1'b0, tl.qy});
    fx = zero || qx > 33'sd32767 || qx < -33'sd32768;
    fy = zero || qy > 33'sd32767 || qy < -33'sd32768;
    if (zero) rsx = tl.nx_neg ? -16'sd32768 : 16'sd32767;
    else if (fx) rsx = qx[32] ? -16'sd32768 : 16'sd32767;
    else rsx = 16'(qx) + $signed({6'd0, tl.cx});
    if (zero) rsy = tl.ny_neg ? -16'sd32768 : 16'sd32767;
    else if (fy) rsy = qy[32] ? -16'sd32768 : 16'sd32767;
    else rsy = 16'(qy) + $signed({6'd0, tl.cy});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= tl.valid;
      out_r <= '{tl.idx, rsx, rsy, tl.depth, fx || fy};
    end
  end

  assign out_valid = out_valid_r;
  assign out_data = out_r;

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("input ready disagrees with output stall");
  a_zero_fault: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.depth == 16'sd0 |-> out_data.divide_fault)
    else $error("zero depth without fault");

endmodule

/* design/vtx_div_cell.sv */
// Divider cell: one restoring step of both unsigned quotients
`timescale 1ns / 1ps
module vtx_div_cell
  import vtx_pkg::*;
#(
  parameter int BIT_POS = 31
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      adv,
  input  div_cell_t cell_in,
  output div_cell_t cell_out
);

  div_cell_t cell_r, cell_nxt;
  logic [15:0] dmag;
  logic [47:0] dsh;

  always_comb begin
    dmag = cell_in.den[15] ? 16'(-cell_in.den) : cell_in.den;
    dsh = {32'd0, dmag} << BIT_POS;
    cell_nxt = cell_in;
    if ({16'd0, cell_in.rx} >= dsh) begin
      cell_nxt.rx = 32'({16'd0, cell_in.rx} - dsh);
      cell_nxt.qx[BIT_POS] = 1'b1;
    end
    if ({16'd0, cell_in.ry} >= dsh) begin
      cell_nxt.ry = 32'({16'd0, cell_in.ry} - dsh);
      cell_nxt.qy[BIT_POS] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r.valid <= 1'b0;
    end else if (adv) begin
      cell_r <= cell_nxt;
    end
  end

  assign cell_out = cell_r;

endmodule

/* design/vtx_row_mac.sv */
// Row cell: pairwise-product sum of one matrix row over one registered stage
`timescale 1ns / 1ps
module vtx_row_mac
  import vtx_pkg::*;
#(
  parameter int FRACTION_SHIFT = DEF_FRACTION_SHIFT
) (
  input  logic clk,
  input  logic adv,
  input  logic [63:0] coeffs,
  input  logic signed [15:0] x,
  input  logic signed [15:0] y,
  input  logic signed [15:0] z,
  output logic signed [31:0] row_sum,
  output logic signed [15:0] corr
);

  logic signed [15:0] m0, m1, m2, t0, t1;
  logic signed [31:0] p01_r, p2_r, pxy_r, pm_r;

  always_comb begin
    m0 = coeffs[15:0];
    m1 = coeffs[31:16];
    m2 = coeffs[47:32];
    t0 = m0 + y;
    t1 = m1 + x;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p01_r <= t0 * t1;
      p2_r <= m2 * z;
      pxy_r <= x * y;
      pm_r <= m0 * m1;
    end
  end

  assign row_sum = p01_r + p2_r - pxy_r;
  assign corr = 16'(pm_r >>> FRACTION_SHIFT);

endmodule

/* tb/vertex_transform_project_test.sv */
// Testbench: directed and random vertices through the transform, checked against a predictor
`timescale 1ns / 1ps
module vertex_transform_project_test;
  import vtx_pkg::*;

  localparam int FRAC = DEF_FRACTION_SHIFT;
  localparam int LATENCY = 35;
  localparam int IDLE_LIMIT = 20000;
  localparam int N_DIRECTED = 14;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_beat_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_beat_t out_data;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [5:0] cfg_paddr = '0;
  logic [63:0] cfg_pwdata = '0;
  logic [63:0] cfg_prdata;
  logic cfg_pready;

  vertex_transform_project dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  logic [63:0] row_x, row_y, row_z;
  logic [9:0] cen_x, cen_y;
  out_beat_t screen_q[$];
  int errors = 0;
  int idle_cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_recv = 1'b0;

  typedef struct {
    in_beat_t v;
    bit known;
    out_beat_t r;
  } vec_row_t;
  vec_row_t vec_rows[N_DIRECTED];

  function automatic longint coeff(logic [63:0] r, int k);
    return longint'($signed(r[16*k +: 16]));
  endfunction

  function automatic longint w16(longint v);
    return longint'($signed(v[15:0]));
  endfunction

  function automatic longint w32(longint v);
    return longint'($signed(v[31:0]));
  endfunction

  function automatic longint pair_sum(logic [63:0] r, longint x, longint y, longint z);
    return w32(w16(coeff(r, 0) + y) * w16(coeff(r, 1) + x) + coeff(r, 2) * z - x * y);
  endfunction

  function automatic longint pair_corr(logic [63:0] r);
    return w16((coeff(r, 0) * coeff(r, 1)) >>> FRAC);
  endfunction

  function automatic longint plane_num(logic [63:0] r, longint x, longint y, longint z);
    longint off;
    off = (coeff(r, 3) - pair_corr(r)) * 256;
    return w32((pair_sum(r, x, y, z) >>> (FRAC - XY_EXTRA_BITS)) + w32(off));
  endfunction

  function automatic longint divide_to_screen(longint num, longint den, longint c,
                                              ref bit fault);
    longint q;
    if (den == 0) begin
      fault = 1'b1;
      return (num >= 0) ? 32767 : -32768;
    end
    q = num / den;
    if (q > 32767) begin
      fault = 1'b1;
      return 32767;
    end
    if (q < -32768) begin
      fault = 1'b1;
      return -32768;
    end
    return w16(q + c);
  endfunction

  function automatic out_beat_t project_vertex(in_beat_t v);
    out_beat_t r;
    longint x, y, z, nx, ny, zp;
    bit fault;
    fault = 1'b0;
    x = longint'(v.x_coord);
    y = longint'(v.y_coord);
    z = longint'(v.z_coord);
    nx = plane_num(row_x, x, y, z);
    ny = plane_num(row_y, x, y, z);
    zp = w16(w16(pair_sum(row_z, x, y, z) >>> FRAC) + w16(coeff(row_z, 3) - pair_corr(row_z)));
    r.vertex_index_out = v.vertex_index;
    r.screen_x = 16'(divide_to_screen(nx, zp, longint'(cen_x), fault));
    r.screen_y = 16'(divide_to_screen(ny, zp, longint'(cen_y), fault));
    r.depth = 16'(zp);
    r.divide_fault = fault;
    return r;
  endfunction

  task automatic write_reg(reg_idx_t idx, logic [63:0] value);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= 6'(8 * int'(idx));
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    case (idx)
      REG_ROW_X: row_x = value;
      REG_ROW_Y: row_y = value;
      REG_ROW_Z: row_z = value;
      REG_CENTER_X: cen_x = value[9:0];
      REG_CENTER_Y: cen_y = value[9:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (screen_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic send_vertex(in_beat_t v, bit known, out_beat_t r);
    while (($urandom_range(99) < send_idle_pct)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= v;
    screen_q.push_back(known ? r : project_vertex(v));
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  function automatic in_beat_t rand_vertex();
    in_beat_t v;
    v.vertex_index = 10'($urandom);
    case ($urandom_range(3))
      0: begin
        v.x_coord = 16'($urandom);
        v.y_coord = 16'($urandom);
        v.z_coord = 16'($urandom);
      end
      default: begin
        v.x_coord = 16'($signed($urandom_range(4000)) - 2000);
        v.y_coord = 16'($signed($urandom_range(4000)) - 2000);
        v.z_coord = 16'($signed($urandom_range(4000)) - 2000);
      end
    endcase
    return v;
  endfunction

  function automatic logic [63:0] rand_row(bit perspective);
    logic [63:0] r;
    r = {$urandom, $urandom};
    if (perspective) begin
      r[15:0] = 16'($signed($urandom_range(8192)) - 4096);
      r[31:16] = 16'($signed($urandom_range(8192)) - 4096);
      r[47:32] = 16'($urandom_range(4096, 1024));
      r[63:48] = 16'($urandom_range(2000, 200));
    end
    return r;
  endfunction

  always @(posedge clk) begin
    if (hold_recv) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (screen_q.size() == 0) begin
        $error("result with no vertex pending: index %0d", out_data.vertex_index_out);
        errors++;
      end else begin
        out_beat_t e;
        e = screen_q.pop_front();
        if (out_data.vertex_index_out !== e.vertex_index_out) begin
          $error("vertex_index_out exp %0d got %0d", e.vertex_index_out,
                 out_data.vertex_index_out);
          errors++;
        end
        if (out_data.screen_x !== e.screen_x) begin
          $error("screen_x exp %0d got %0d", e.screen_x, out_data.screen_x);
          errors++;
        end
        if (out_data.screen_y !== e.screen_y) begin
          $error("screen_y exp %0d got %0d", e.screen_y, out_data.screen_y);
          errors++;
        end
        if (out_data.depth !== e.depth) begin
          $error("depth exp %0d got %0d", e.depth, out_data.depth);
          errors++;
        end
        if (out_data.divide_fault !== e.divide_fault) begin
          $error("divide_fault exp %0d got %0d", e.divide_fault, out_data.divide_fault);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_psel || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic vec_row_t vrow(logic [9:0] i, int x, int y, int z, bit known,
                                    int sx, int sy, int d, bit f);
    vec_row_t t;
    t.v = '{vertex_index: i, x_coord: 16'(x), y_coord: 16'(y), z_coord: 16'(z)};
    t.known = known;
    t.r = '{vertex_index_out: i, screen_x: 16'(sx), screen_y: 16'(sy), depth: 16'(d),
            divide_fault: f};
    return t;
  endfunction

  initial begin
    out_beat_t none;
    int phase;
    none = '0;
    row_x = '0;
    row_y = '0;
    row_z = '0;
    cen_x = 10'd128;
    cen_y = 10'd128;
    // all-zero matrix after reset: depth zero, numerators zero -> positive saturation
    vec_rows[0] = vrow(10'd0, 0, 0, 0, 1, 32767, 32767, 0, 1);
    vec_rows[1] = vrow(10'd1023, 32767, 32767, 32767, 0, 0, 0, 0, 0);
    vec_rows[2] = vrow(10'd512, -32768, -32768, -32768, 0, 0, 0, 0, 0);
    vec_rows[3] = vrow(10'd3, 32767, -32768, 0, 0, 0, 0, 0, 0);
    vec_rows[4] = vrow(10'd4, -32768, 32767, 1, 0, 0, 0, 0, 0);
    vec_rows[5] = vrow(10'd5, 1, -1, -32768, 0, 0, 0, 0, 0);
    vec_rows[6] = vrow(10'd6, -1, 1, 32767, 0, 0, 0, 0, 0);
    vec_rows[7] = vrow(10'd7, 100, -100, 4096, 0, 0, 0, 0, 0);
    vec_rows[8] = vrow(10'd8, -21846, 21845, -21846, 0, 0, 0, 0, 0);
    vec_rows[9] = vrow(10'd9, 21845, -21846, 21845, 0, 0, 0, 0, 0);
    vec_rows[10] = vrow(10'd10, 0, 0, -4096, 0, 0, 0, 0, 0);
    vec_rows[11] = vrow(10'd11, 4095, 4096, 0, 0, 0, 0, 0, 0);
    vec_rows[12] = vrow(10'd12, 8, -8, 1, 0, 0, 0, 0, 0);
    vec_rows[13] = vrow(10'd13, -7, 7, -1, 0, 0, 0, 0, 0);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_vertex(vec_rows[0].v, vec_rows[0].known, vec_rows[0].r);
    drain();
    // identity-like perspective set-up, then extreme X and Y row coefficients with a zero Z row
    write_reg(REG_ROW_X, {16'sd0, 16'sd0, 16'sd0, 16'sd4096});
    write_reg(REG_ROW_Y, {16'sd0, 16'sd0, 16'sd4096, 16'sd0});
    write_reg(REG_ROW_Z, {16'sd1000, 16'sd4096, 16'sd0, 16'sd0});
    write_reg(REG_CENTER_X, 64'd160);
    write_reg(REG_CENTER_Y, 64'd100);
    for (int i = 1; i < N_DIRECTED; i++)
      send_vertex(vec_rows[i].v, vec_rows[i].known, vec_rows[i].r);
    drain();
    write_reg(REG_ROW_X, {16'h7fff, 16'h8000, 16'h7fff, 16'h8000});
    write_reg(REG_ROW_Y, {16'h8000, 16'h7fff, 16'h8000, 16'h7fff});
    write_reg(REG_ROW_Z, {16'h0000, 16'h0000, 16'h0000, 16'h0000});
    write_reg(REG_CENTER_X, 64'd1023);
    write_reg(REG_CENTER_Y, 64'd0);
    for (int i = 1; i < N_DIRECTED; i++)
      send_vertex(vec_rows[i].v, 1'b0, none);
    drain();

    for (phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
        3: begin send_idle_pct = 24; recv_stall_pct = 24; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      write_reg(REG_ROW_X, rand_row(phase != 4));
      write_reg(REG_ROW_Y, rand_row(phase != 4));
      write_reg(REG_ROW_Z, rand_row(phase != 4));
      write_reg(REG_CENTER_X, 64'($urandom_range(1023)));
      write_reg(REG_CENTER_Y, 64'($urandom_range(1023)));
      if (phase == 0) begin
        fork
          begin
            hold_recv = 1'b1;
            repeat (200) @(posedge clk);
            hold_recv = 1'b0;
          end
        join_none
      end
      for (int n = 0; n < 96; n++) begin
        send_vertex(rand_vertex(), 1'b0, none);
        if (n == 48 && phase == 3) begin
          in_valid <= 1'b0;
          while (screen_q.size() != 0) @(posedge clk);
        end
      end
      drain();
    end

    send_idle_pct = 0;
    recv_stall_pct = 0;
    drain();
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
